// ----- rtl/ssat_pkg.sv -----
// Shared types and constants for the sparse score accumulator with top-k selection.
package ssat_pkg;

	localparam int unsigned ScoreW = 40;
	localparam int unsigned IdW    = 32;
	localparam int unsigned KW     = 7;

	localparam logic [1:0] CMD_ACC  = 2'd0;
	localparam logic [1:0] CMD_SCAN = 2'd1;
	localparam logic [1:0] CMD_EMIT = 2'd2;

	localparam logic [KW-1:0] TOP_COUNT_RESET = 7'd10;

	localparam logic signed [ScoreW-1:0] ACC_MAX = {1'b0, {(ScoreW-1){1'b1}}};
	localparam logic signed [ScoreW-1:0] ACC_MIN = {1'b1, {(ScoreW-1){1'b0}}};

	typedef struct packed {
		logic [1:0]         cmd;
		logic [11:0]        local_doc;
		logic signed [15:0] doc_value;
		logic signed [15:0] query_value;
		logic [31:0]        global_id;
	} in_word_t;

	typedef struct packed {
		logic [31:0]        doc_id;
		logic signed [39:0] score;
		logic               is_empty;
		logic               last;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC_RD,
		ST_ACC_MUL,
		ST_ACC_WR,
		ST_SCAN_RD,
		ST_SCAN_OFFER,
		ST_FIND,
		ST_FIND_WAIT,
		ST_REPLACE,
		ST_EMIT_FIND,
		ST_EMIT_WAIT,
		ST_EMIT_OUT,
		ST_EMIT_EMPTY
	} state_t;

	// (score, id) ordering: true when a is greater than b
	function automatic logic entry_gt(logic signed [ScoreW-1:0] sa, logic [IdW-1:0] ia,
			logic signed [ScoreW-1:0] sb, logic [IdW-1:0] ib);
		if (sa != sb) begin
			return sa > sb;
		end
		return ia > ib;
	endfunction

endpackage

// ----- rtl/ssat_cfg.sv -----
// APB register file holding top_count.
module ssat_cfg import ssat_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic          paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output logic [KW-1:0] top_count
);
	logic [KW-1:0] top_q;

	// write register zero on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= TOP_COUNT_RESET;
		end else if (psel && penable && pwrite && paddr == 1'b0) begin
			top_q <= pwdata[KW-1:0];
		end
	end

	assign pready    = 1'b1;
	assign prdata    = (paddr == 1'b0) ? {{(32-KW){1'b0}}, top_q} : 32'd0;
	assign top_count = top_q;
endmodule

// ----- rtl/ssat_core.sv -----
// Sequencer with score store, kept-entry memories and one shared compare unit.
module ssat_core import ssat_pkg::*; #(
	parameter int unsigned MAX_DOCS = 4096,
	parameter int unsigned MAX_TOP  = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [KW-1:0] top_count,
	input  logic          in_valid,
	output logic          in_ready,
	input  in_word_t      in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output out_word_t     out_data
);
	localparam int unsigned DocAw = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
	localparam int unsigned HAw   = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;
	localparam int unsigned NW    = $clog2(MAX_TOP + 1);
	localparam logic [KW-1:0] MaxTopK = KW'(MAX_TOP);

	state_t state_q, state_d;

	in_word_t          item_q;
	logic [NW-1:0]     count_q;
	logic [MAX_TOP-1:0] done_q;
	logic [HAw-1:0]    idx_q;
	logic [NW-1:0]     left_q;
	logic [HAw-1:0]    best_q;
	logic              have_q;
	logic signed [ScoreW-1:0] best_s_q;
	logic [IdW-1:0]    best_id_q;
	logic signed [ScoreW-1:0] acc_q;
	logic signed [31:0] prod_q;
	logic signed [ScoreW-1:0] sc_q;

	// score store
	logic signed [ScoreW-1:0] store_mem [MAX_DOCS];
	logic signed [ScoreW-1:0] store_rd_q;
	logic               st_we;
	logic [DocAw-1:0]   st_wa;
	logic signed [ScoreW-1:0] st_wd;
	logic [DocAw-1:0]   doc_a;

	// zero the whole score store once after reset
	logic               clr_q;
	logic [DocAw:0]     clr_cnt_q;

	assign doc_a = DocAw'(item_q.local_doc);

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[st_wa] <= st_wd;
		end
		store_rd_q <= store_mem[doc_a];
	end

	// kept entries
	logic signed [ScoreW-1:0] hs_mem [MAX_TOP];
	logic [IdW-1:0]     hi_mem [MAX_TOP];
	logic signed [ScoreW-1:0] hs_rd_q;
	logic [IdW-1:0]     hi_rd_q;
	logic               h_we;
	logic [HAw-1:0]     h_wa;
	logic [HAw-1:0]     h_ra;
	logic signed [ScoreW-1:0] h_wd;

	always_ff @(posedge clk) begin
		if (h_we) begin
			hs_mem[h_wa] <= h_wd;
			hi_mem[h_wa] <= item_q.global_id;
		end
		hs_rd_q <= hs_mem[h_ra];
		hi_rd_q <= hi_mem[h_ra];
	end

	logic [KW-1:0] k_eff;
	always_comb begin
		if (top_count == '0) begin
			k_eff = KW'(1);
		end else if (top_count > MaxTopK) begin
			k_eff = MaxTopK;
		end else begin
			k_eff = top_count;
		end
	end

	// shared compare unit
	logic cmp_gt;
	assign cmp_gt = entry_gt(hs_rd_q, hi_rd_q, best_s_q, best_id_q);

	logic signed [ScoreW:0] acc_sum;
	assign acc_sum = {acc_q[ScoreW-1], acc_q} - (ScoreW+1)'(prod_q);

	logic doc_ok;
	assign doc_ok = ({4'd0, item_q.local_doc} < 16'(MAX_DOCS)) || (MAX_DOCS > 4095);

	logic is_last;
	assign is_last = (left_q == NW'(1));

	// sequencer
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		out_data = '0;
		st_we = 1'b0;
		st_wa = doc_a;
		st_wd = '0;
		h_we  = 1'b0;
		h_wa  = count_q[HAw-1:0];
		h_ra  = idx_q;
		h_wd  = sc_q;
		if (clr_q) begin
			st_we = 1'b1;
			st_wa = clr_cnt_q[DocAw-1:0];
		end
		case (state_q)
			ST_IDLE: begin
				in_ready = !clr_q;
				if (in_valid && !clr_q) begin
					case (in_data.cmd)
						CMD_ACC:  state_d = ST_ACC_RD;
						CMD_SCAN: state_d = ST_SCAN_RD;
						CMD_EMIT: state_d = (count_q == '0) ? ST_EMIT_EMPTY : ST_EMIT_FIND;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_ACC_RD: state_d = doc_ok ? ST_ACC_MUL : ST_IDLE;
			ST_ACC_MUL: state_d = ST_ACC_WR;
			ST_ACC_WR: begin
				st_we = 1'b1;
				if (acc_sum > (ScoreW+1)'(ACC_MAX)) begin
					st_wd = ACC_MAX;
				end else if (acc_sum < $signed({1'b1, ACC_MIN})) begin
					st_wd = ACC_MIN;
				end else begin
					st_wd = acc_sum[ScoreW-1:0];
				end
				state_d = ST_IDLE;
			end
			ST_SCAN_RD: state_d = doc_ok ? ST_SCAN_OFFER : ST_IDLE;
			ST_SCAN_OFFER: begin
				st_we = 1'b1;
				st_wd = '0;
				h_wd  = store_rd_q;
				if ({{(KW-NW+1){1'b0}}, count_q} < {1'b0, k_eff}) begin
					h_we = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_FIND;
				end
			end
			ST_FIND: state_d = ST_FIND_WAIT;
			ST_FIND_WAIT: state_d = is_last ? ST_REPLACE : ST_FIND_WAIT;
			ST_REPLACE: begin
				h_wa = best_q;
				h_we = (sc_q < best_s_q);
				state_d = ST_IDLE;
			end
			ST_EMIT_FIND: state_d = ST_EMIT_WAIT;
			ST_EMIT_WAIT: state_d = is_last ? ST_EMIT_OUT : ST_EMIT_WAIT;
			ST_EMIT_OUT: begin
				out_valid = 1'b1;
				out_data.doc_id = best_id_q;
				out_data.score  = best_s_q;
				out_data.last   = ($countones(done_q) + 1 == int'(count_q));
				if (out_ready) begin
					state_d = out_data.last ? ST_IDLE : ST_EMIT_FIND;
				end
			end
			ST_EMIT_EMPTY: begin
				out_valid = 1'b1;
				out_data.is_empty = 1'b1;
				out_data.last = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			done_q    <= '0;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == (DocAw+1)'(MAX_DOCS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (state_q == ST_SCAN_OFFER && h_we) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == ST_EMIT_OUT && out_ready) begin
				if (out_data.last) begin
					count_q <= '0;
					done_q  <= '0;
				end else begin
					done_q[best_q] <= 1'b1;
				end
			end
		end
	end

	// datapath registers; the scan walks read address idx_q, data follows in the next cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && in_ready) begin
			item_q <= in_data;
		end
		if (state_q == ST_ACC_RD) begin
			prod_q <= item_q.doc_value * item_q.query_value;
		end
		if (state_q == ST_ACC_MUL) begin
			acc_q  <= store_rd_q;
		end
		if (state_q == ST_SCAN_OFFER) begin
			sc_q <= store_rd_q;
		end
		if (state_q == ST_SCAN_OFFER || state_q == ST_IDLE
				|| (state_q == ST_EMIT_OUT && out_ready)) begin
			idx_q  <= '0;
			left_q <= count_q;
			have_q <= 1'b0;
		end
		if (state_q == ST_FIND || state_q == ST_FIND_WAIT || state_q == ST_EMIT_FIND
				|| state_q == ST_EMIT_WAIT) begin
			idx_q <= idx_q + 1'b1;
		end
		// compare the entry read last cycle against the running pick
		if (state_q == ST_FIND_WAIT) begin
			left_q <= left_q - 1'b1;
			if (!have_q || cmp_gt) begin
				have_q <= 1'b1; best_q <= idx_q - 1'b1;
				best_s_q <= hs_rd_q; best_id_q <= hi_rd_q;
			end
		end
		if (state_q == ST_EMIT_WAIT) begin
			left_q <= left_q - 1'b1;
			if (!done_q[idx_q - 1'b1] && (!have_q || !cmp_gt)) begin
				have_q <= 1'b1; best_q <= idx_q - 1'b1;
				best_s_q <= hs_rd_q; best_id_q <= hi_rd_q;
			end
		end
	end
endmodule

// ----- rtl/sparse_score_accumulate_topk.sv -----
// Accumulate steps through ACC_RD, ACC_MUL and ACC_WR. Scan: SCAN_RD, SCAN_OFFER,
// then, when not inserting, FIND, a FIND_WAIT walk over the kept entries, REPLACE.
// Emit: after the accept, one selection walk (EMIT_FIND, EMIT_WAIT) per result,
// then EMIT_OUT; an empty emit goes to EMIT_EMPTY. Steps set by the single shared
// compare unit and single memory ports. After reset a clearing pass zeroes the
// score store; no item is accepted meanwhile. Configuration writes are taken always.
module sparse_score_accumulate_topk import ssat_pkg::*; #(
	parameter int unsigned MAX_DOCS = 4096,
	parameter int unsigned MAX_TOP  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data
);
	logic [KW-1:0] top_count;

	ssat_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.top_count
	);

	ssat_core #(.MAX_DOCS(MAX_DOCS), .MAX_TOP(MAX_TOP)) u_core (
		.clk, .arst_n, .top_count, .in_valid, .in_ready, .in_data,
		.out_valid, .out_ready, .out_data
	);
endmodule

// ----- rtl/ssat_checker.sv -----
// Port-level checks for the top level, bound in below.
module ssat_checker import ssat_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_word_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);
	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// drop input acceptance while a result is offered
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while result pending");

	// empty marker always ends a run
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_empty |-> out_data.last && out_data.score == '0)
		else $error("empty result malformed");

	// accepting a known command leaves the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.cmd == CMD_ACC || in_data.cmd == CMD_SCAN
			|| in_data.cmd == CMD_EMIT) |=> !in_ready)
		else $error("ready right after accept");
endmodule

bind sparse_score_accumulate_topk ssat_checker u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
);
